/* rtl/core/sdu_pkg.sv */
// Shared types, constants and helpers for the source direction unit vector block.
// No dependencies.
package sdu_pkg;

  localparam int CORDIC_STAGES_DEF = 30;
  localparam int ANGLE_W = 34;

  localparam logic [31:0] EPOCH_RESET = 32'd1689534464;
  localparam logic signed [32:0] J2000_MJD_Q15 = 33'sd1689010176;
  localparam logic signed [57:0] RECIP_YEAR_Q32 = 58'sd11758980;
  localparam logic [31:0] ARCSEC_MICRO_Q69 = 32'd2861834848;
  localparam logic signed [65:0] FOUR_OVER_PI_Q30 = 66'sd1367130551;
  localparam logic signed [63:0] PI_Q31 = 64'sd6746518852;
  localparam logic signed [63:0] PI4_Q62 = 64'sh3243F6A8885A308D;
  localparam logic signed [52:0] GAIN_Q50 = 53'sd683706022956410;
  localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

  typedef struct packed {
    logic signed [31:0] right_ascension;
    logic signed [31:0] declination;
    logic signed [31:0] ra_rate;
    logic signed [31:0] dec_motion;
  } req_t;

  typedef struct packed {
    logic signed [31:0] unit_x;
    logic signed [31:0] unit_y;
    logic signed [31:0] unit_z;
  } rsp_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
  } ob_status_t;

  // atan(2^-i) in Q62; elaboration-time only
  function automatic logic signed [63:0] atan_q62(input int i);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    int k;
    sum = '0;
    if (i == 0) begin
      sum = PI4_Q62;
    end else begin
      for (k = 0; k < 32; k++) begin
        if (i * (2 * k + 1) < 63) begin
          term = ((64'sd1 <<< 62) >>> (i * (2 * k + 1))) / 64'(2 * k + 1);
          sum = (k % 2 == 1) ? sum - term : sum + term;
        end
      end
    end
    return sum;
  endfunction

  // saturate to +-1.0 in Q30
  function automatic logic signed [31:0] sat_q30(input logic signed [65:0] v);
    logic signed [65:0] lim;
    lim = 66'(ONE_Q30);
    if (v > lim) return ONE_Q30;
    if (v < -lim) return -ONE_Q30;
    return v[31:0];
  endfunction

endpackage

/* rtl/core/sdu_motion.sv */
// Proper motion pipeline: epoch to years, then angle advance for RA and Dec.
// Depends on sdu_pkg.
module sdu_motion (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  sdu_pkg::req_t                       req,
  input  logic [31:0]                         epoch,
  output logic                                valid,
  output logic signed [sdu_pkg::ANGLE_W-1:0]  angle_ra,
  output logic signed [sdu_pkg::ANGLE_W-1:0]  angle_dec
);

  logic [4:0] v;

  // stage 1: days since J2000 times 1/365.25
  logic signed [32:0] days;
  logic signed [57:0] yprod;
  assign days = $signed({1'b0, epoch}) - sdu_pkg::J2000_MJD_Q15;

  // stage 2: round to Q22 years, ties away from zero
  logic [57:0]        ym;
  logic [32:0]        yr;
  logic signed [31:0] years;
  assign ym = yprod[57] ? 58'(-yprod) : 58'(yprod);
  assign yr = 33'((ym + 58'd16777216) >> 25);

  logic signed [31:0] a0_1 [2];
  logic signed [31:0] a0_2 [2];
  logic signed [31:0] a0_3 [2];
  logic signed [31:0] a0_4 [2];
  logic signed [31:0] rt_1 [2];
  logic signed [31:0] rt_2 [2];
  logic signed [63:0] pr   [2];
  logic [62:0]        hi   [2];
  logic [63:0]        lo   [2];
  logic               neg  [2];
  logic signed [sdu_pkg::ANGLE_W-1:0] ang [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yprod   <= 58'(days) * sdu_pkg::RECIP_YEAR_Q32;
      a0_1[0] <= req.right_ascension;
      a0_1[1] <= req.declination;
      rt_1[0] <= req.ra_rate;
      rt_1[1] <= req.dec_motion;
      years   <= yprod[57] ? -32'(yr) : 32'(yr);
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [63:0] m;
    logic [63:0] mid;
    logic [33:0] r;
    logic signed [sdu_pkg::ANGLE_W-1:0] delta;
    assign m     = pr[l][63] ? 64'(-pr[l]) : 64'(pr[l]);
    assign mid   = 64'(hi[l]) + 64'(lo[l][63:32]) + 64'd536870912;
    assign r     = mid[63:30];
    assign delta = neg[l] ? -$signed(r) : $signed(r);

    always_ff @(posedge clk) begin
      if (en) begin
        a0_2[l] <= a0_1[l];
        rt_2[l] <= rt_1[l];
        pr[l]   <= 64'(rt_2[l]) * 64'(years);
        a0_3[l] <= a0_2[l];
        hi[l]   <= 63'(m[62:32]) * 63'(sdu_pkg::ARCSEC_MICRO_Q69);
        lo[l]   <= 64'(m[31:0]) * 64'(sdu_pkg::ARCSEC_MICRO_Q69);
        neg[l]  <= pr[l][63];
        a0_4[l] <= a0_3[l];
        ang[l]  <= sdu_pkg::ANGLE_W'(a0_4[l]) + delta;
      end
    end
  end

  assign valid     = v[4];
  assign angle_ra  = ang[0];
  assign angle_dec = ang[1];

endmodule

/* rtl/core/sdu_sincos.sv */
// Pipelined sine/cosine: quarter-turn reduction then one CORDIC stage per register.
// Depends on sdu_pkg.
module sdu_sincos #(
  parameter int STAGES = sdu_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [sdu_pkg::ANGLE_W-1:0] angle,
  output logic signed [31:0]                 c,
  output logic signed [31:0]                 s
);

  logic signed [65:0] ap;
  logic signed [31:0] res;
  logic [1:0]         q2;
  logic [65:0]        t;
  logic [31:0]        phase;
  logic [1:0]         qn;
  logic [31:0]        qoff;

  assign t     = 66'(ap + 66'sd536870912);
  assign phase = t[61:30];
  assign qn    = 2'((phase + 32'h2000_0000) >> 30);
  assign qoff  = {qn, 30'd0};

  logic signed [52:0] cx [STAGES+1];
  logic signed [52:0] cy [STAGES+1];
  logic signed [63:0] cz [STAGES+1];
  logic [1:0]         cq [STAGES+1];

  assign cx[0] = sdu_pkg::GAIN_Q50;
  assign cy[0] = '0;

  always_ff @(posedge clk) begin
    if (en) begin
      ap    <= sdu_pkg::FOUR_OVER_PI_Q30 * 66'(angle);
      res   <= $signed(phase - qoff);
      q2    <= qn;
      cz[0] <= 64'(res) * sdu_pkg::PI_Q31;
      cq[0] <= q2;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [63:0] ATAN = sdu_pkg::atan_q62(i);
    logic signed [52:0] dx;
    logic signed [52:0] dy;
    assign dx = cy[i] >>> i;
    assign dy = cx[i] >>> i;
    if (i > 0) begin : g_reg
      always_ff @(posedge clk) begin
        if (en) begin
          cx[i+1] <= (cz[i] >= 0) ? cx[i] - dx : cx[i] + dx;
          cy[i+1] <= (cz[i] >= 0) ? cy[i] + dy : cy[i] - dy;
          cz[i+1] <= (cz[i] >= 0) ? cz[i] - ATAN : cz[i] + ATAN;
          cq[i+1] <= cq[i];
        end
      end
    end else begin : g_first
      // stage 0 starts from the fixed gain vector
      always_ff @(posedge clk) begin
        if (en) begin
          cx[1] <= (cz[0] >= 0) ? cx[0] - dx : cx[0] + dx;
          cy[1] <= (cz[0] >= 0) ? cy[0] + dy : cy[0] - dy;
          cz[1] <= (cz[0] >= 0) ? cz[0] - ATAN : cz[0] + ATAN;
          cq[1] <= cq[0];
        end
      end
    end
  end

  logic signed [31:0] cr;
  logic signed [31:0] sr;
  assign cr = sdu_pkg::sat_q30(66'((cx[STAGES] + 53'sd524288) >>> 20));
  assign sr = sdu_pkg::sat_q30(66'((cy[STAGES] + 53'sd524288) >>> 20));

  always_ff @(posedge clk) begin
    if (en) begin
      case (cq[STAGES])
        2'd0: begin
          c <= cr;
          s <= sr;
        end
        2'd1: begin
          c <= -sr;
          s <= cr;
        end
        2'd2: begin
          c <= -cr;
          s <= -sr;
        end
        default: begin
          c <= sr;
          s <= -cr;
        end
      endcase
    end
  end

endmodule

/* rtl/core/sdu_outbuf.sv */
// Two-entry output buffer that decouples the pipeline from the receiver.
// Depends on sdu_pkg.
module sdu_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sdu_pkg::rsp_t       din,
  output logic                valid,
  input  logic                ready,
  output sdu_pkg::rsp_t       dout,
  output sdu_pkg::ob_status_t status
);

  sdu_pkg::rsp_t mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       pop;

  assign pop = valid & ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= din;
  end

  assign valid        = count != 2'd0;
  assign dout         = mem[rp];
  assign status.count = count;
  assign status.full  = count == 2'd2;

endmodule

/* rtl/core/source_direction_unit_vector_top.sv */
// Top level of the source direction unit vector block.
// Depends on sdu_pkg, sdu_motion, sdu_sincos, sdu_outbuf.
//
// Usage:
//   in channel (in_valid/in_ready/in_req) carries one source request: J2000
//   RA/Dec in Q3.29 radians and proper motion rates in 1e-6 arcsec/yr.
//   out channel (out_valid/out_ready/out_rsp) returns the Q1.30 unit vector.
//   cfg_we/cfg_wdata writes the mean epoch (MJD, Q17.15); write only while idle.
// Pipeline: 5 motion stages, CORDIC_STAGES + 4 sin/cos stages, 1 product stage
//   and 1 buffer register lie between accept and out_valid.
// Throughput: one request per cycle while the output buffer is not full; every
//   stage is a single register and the CORDIC has one stage per iteration.
// Stall: the whole pipeline holds while the two-entry output buffer is full;
//   in_ready drops only then, so new requests keep flowing while one result
//   waits. Nothing is dropped or duplicated.
// Reset: clears valid bits and the buffer, epoch returns to MJD 51560.5.

module source_direction_unit_vector_top #(
  parameter int CORDIC_STAGES = sdu_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sdu_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_ready,
  output sdu_pkg::rsp_t out_rsp,
  input  logic          cfg_we,
  input  logic [31:0]   cfg_wdata
);

  localparam int SC_LAT = CORDIC_STAGES + 4;

  logic [31:0] epoch;
  logic        en;
  sdu_pkg::ob_status_t ob_st;

  // global advance: pipeline moves whenever the buffer has room
  assign en       = ~ob_st.full;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch <= sdu_pkg::EPOCH_RESET;
    end else if (cfg_we) begin
      epoch <= cfg_wdata;
    end
  end

  logic                               mot_valid;
  logic signed [sdu_pkg::ANGLE_W-1:0] ang_ra;
  logic signed [sdu_pkg::ANGLE_W-1:0] ang_dec;

  sdu_motion u_motion (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .req       (in_req),
    .epoch     (epoch),
    .valid     (mot_valid),
    .angle_ra  (ang_ra),
    .angle_dec (ang_dec)
  );

  logic signed [31:0] cra, sra, cdec, sdec;

  sdu_sincos #(.STAGES(CORDIC_STAGES)) u_sc_ra (
    .clk   (clk),
    .en    (en),
    .angle (ang_ra),
    .c     (cra),
    .s     (sra)
  );

  sdu_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dec (
    .clk   (clk),
    .en    (en),
    .angle (ang_dec),
    .c     (cdec),
    .s     (sdec)
  );

  // valid bits matching the sin/cos pipeline depth
  logic [SC_LAT-1:0] vl;
  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= '0;
    end else if (en) begin
      vl <= {vl[SC_LAT-2:0], mot_valid};
    end
  end

  // product stage: cos dec times cos/sin ra; sin dec passes through
  logic               pv;
  logic signed [63:0] pa;
  logic signed [63:0] pb;
  logic signed [31:0] pz;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= vl[SC_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa <= 64'(cdec) * 64'(cra);
      pb <= 64'(cdec) * 64'(sra);
      pz <= sdec;
    end
  end

  // round to Q30 and saturate on the way into the buffer
  sdu_pkg::rsp_t res;
  logic          push;
  assign res.unit_x = sdu_pkg::sat_q30(66'((66'(pa) + 66'sd536870912) >>> 30));
  assign res.unit_y = sdu_pkg::sat_q30(66'((66'(pb) + 66'sd536870912) >>> 30));
  assign res.unit_z = pz;
  assign push       = pv & en;

  sdu_outbuf u_outbuf (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (res),
    .valid  (out_valid),
    .ready  (out_ready),
    .dout   (out_rsp),
    .status (ob_st)
  );

`ifndef SYNTHESIS
  // buffer never overfills
  a_count_max: assert property (@(posedge clk) disable iff (rst) ob_st.count != 2'd3)
    else $error("output buffer overflow");

  // a stalled result in the product stage stays put
  a_stall_hold: assert property (@(posedge clk) disable iff (rst) (pv && !en) |=> pv)
    else $error("stalled result lost");

  // push without pop grows the buffer by one
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    (push && !(out_valid && out_ready)) |=> ob_st.count == $past(ob_st.count) + 2'd1)
    else $error("buffer count mismatch");
`endif

endmodule

/* dv/tb_source_direction_unit_vector_top.sv */
// Testbench for source_direction_unit_vector_top: random and directed sources checked
// against an integer model of proper motion, CORDIC sin/cos and the unit vector product.
// Depends on sdu_pkg and the RTL of the block.
module tb_source_direction_unit_vector_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES    = 30;
  localparam int LATENCY   = STAGES + 11;
  localparam int MAX_CYCLE = 400000;

  // Scoreboard: holds its own copy of the epoch and predicts each vector.
  class direction_scoreboard;
    logic [31:0]   epoch;
    sdu_pkg::rsp_t expected_vectors[$];
    int            mismatches;

    function new();
      epoch = sdu_pkg::EPOCH_RESET;
      mismatches = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
      mismatches++;
    endtask

    static function longint sat_one(longint v);
      if (v > 64'sd1073741824) return 64'sd1073741824;
      if (v < -64'sd1073741824) return -64'sd1073741824;
      return v;
    endfunction

    // round half away from zero of p / 2^s
    static function longint round_away(longint p, int s);
      longint unsigned m;
      m = p < 0 ? -p : p;
      m = (m + (64'd1 << (s - 1))) >> s;
      return p < 0 ? -longint'(m) : longint'(m);
    endfunction

    // rate*years scaled by 1e-6 arcsec to Q29 radians
    static function longint motion_q29(longint p);
      logic [127:0] m, prod;
      longint r;
      m = p < 0 ? 128'(-p) : 128'(p);
      prod = ((m * 128'(sdu_pkg::ARCSEC_MICRO_Q69)) >> 32) + (128'd1 << 29);
      r = longint'(prod >> 30);
      return p < 0 ? -r : r;
    endfunction

    static function longint arctan_q62(int i);
      longint sum, term;
      int k;
      sum = 0;
      if (i == 0) return 64'sh3243F6A8885A308D;
      for (k = 0; i * (2 * k + 1) < 63; k++) begin
        term = longint'((64'd1 << 62) >> (i * (2 * k + 1))) / longint'(2 * k + 1);
        sum = (k % 2 == 1) ? sum - term : sum + term;
      end
      return sum;
    endfunction

    static function void sine_cosine(longint ang, output longint c, output longint s);
      longint t, x, y, z, dx, dy, cr, sr;
      logic [31:0] phase, resid;
      logic [1:0] quad;
      t = (ang * 64'sd1367130551 + (64'sd1 << 29)) >>> 30;
      phase = t[31:0];
      quad = 2'((phase + 32'h2000_0000) >> 30);
      resid = phase - (32'(quad) << 30);
      z = longint'($signed(resid)) * 64'sd6746518852;
      x = 64'sd683706022956410;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan_q62(i);
        end else begin
          x += dx; y -= dy; z += arctan_q62(i);
        end
      end
      cr = sat_one((x + (64'sd1 << 19)) >>> 20);
      sr = sat_one((y + (64'sd1 << 19)) >>> 20);
      case (quad)
        2'd0: begin c = cr;  s = sr;  end
        2'd1: begin c = -sr; s = cr;  end
        2'd2: begin c = -cr; s = -sr; end
        default: begin c = sr; s = -cr; end
      endcase
    endfunction

    function sdu_pkg::rsp_t predict_direction(sdu_pkg::req_t r);
      longint days, years, ra, dec, cra, sra, cdec, sdec;
      sdu_pkg::rsp_t v;
      days = longint'(epoch) - 64'sd1689010176;
      years = round_away(days * 64'sd11758980, 25);
      ra = longint'(r.right_ascension) + motion_q29(longint'(r.ra_rate) * years);
      dec = longint'(r.declination) + motion_q29(longint'(r.dec_motion) * years);
      sine_cosine(ra, cra, sra);
      sine_cosine(dec, cdec, sdec);
      v.unit_x = 32'(sat_one((cdec * cra + (64'sd1 << 29)) >>> 30));
      v.unit_y = 32'(sat_one((cdec * sra + (64'sd1 << 29)) >>> 30));
      v.unit_z = 32'(sdec);
      return v;
    endfunction

    function void note_source(sdu_pkg::req_t r);
      expected_vectors.push_back(predict_direction(r));
    endfunction

    task check_vector(sdu_pkg::rsp_t got);
      sdu_pkg::rsp_t want;
      if (expected_vectors.size() == 0) begin
        report("unexpected unit_x", got.unit_x, 32'd0);
        return;
      end
      want = expected_vectors.pop_front();
      if (got.unit_x !== want.unit_x) report("unit_x", got.unit_x, want.unit_x);
      if (got.unit_y !== want.unit_y) report("unit_y", got.unit_y, want.unit_y);
      if (got.unit_z !== want.unit_z) report("unit_z", got.unit_z, want.unit_z);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sdu_pkg::req_t in_req = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  sdu_pkg::rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int cycle_count = 0;
  direction_scoreboard sb = new();

  always #10 clk = ~clk;

  source_direction_unit_vector_top #(.CORDIC_STAGES(STAGES)) u_top (
    .clk, .rst, .in_valid, .in_ready, .in_req,
    .out_valid, .out_ready, .out_rsp, .cfg_we, .cfg_wdata
  );

  // Receiver side: check accepted vectors, randomize ready, watch the cycle limit.
  // Reads in the active region see pre-edge values, so no race with the DUT.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) sb.check_vector(out_rsp);
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
    if (cycle_count > MAX_CYCLE) begin
      $display("timeout");
      $display("tb_source_direction_unit_vector_top: FAIL");
      $finish;
    end
  end

  // One request: optional idle gap, then hold valid until accepted.
  task automatic send_request(sdu_pkg::req_t r);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_source(r);
  endtask

  // Epoch write only while idle: drain outstanding vectors, then let the pipe empty.
  task automatic write_epoch(logic [31:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_vectors.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.epoch = value;
  endtask

  function automatic sdu_pkg::req_t make_req(logic [31:0] ra, logic [31:0] dec,
                                             logic [31:0] rr, logic [31:0] dr);
    sdu_pkg::req_t r;
    r.right_ascension = ra;
    r.declination = dec;
    r.ra_rate = rr;
    r.dec_motion = dr;
    return r;
  endfunction

  // Mostly physical sources (RA within one turn either way, Dec within a quarter turn, modest rates), some raw noise.
  function automatic sdu_pkg::req_t random_req();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 2)
      return make_req($urandom, $urandom, $urandom, $urandom);
    return make_req(32'($signed($urandom_range(6746518, 0)) - 3373259) * 32'sd1000,
                    32'($signed($urandom_range(1686630, 0)) - 843315) * 32'sd1000,
                    32'($signed($urandom_range(20000000, 0)) - 10000000),
                    32'($signed($urandom_range(20000000, 0)) - 10000000));
  endfunction

  localparam logic [31:0] HALF_PI_Q29 = 32'sd843314857;
  localparam logic [31:0] PI_Q29      = 32'sd1686629713;
  localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SMIN = 32'h8000_0000;

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset epoch, field extremes, poles, half turn, wrap beyond a half turn.
    tx_idle_pct = 13; rx_idle_pct = 79;
    send_request(make_req(0, 0, 0, 0));
    send_request(make_req(SMAX, SMAX, SMAX, SMAX));
    send_request(make_req(SMIN, SMIN, SMIN, SMIN));
    send_request(make_req(0, HALF_PI_Q29, 0, 0));
    send_request(make_req(0, -HALF_PI_Q29, 0, 0));
    send_request(make_req(PI_Q29, 0, 0, 0));
    send_request(make_req(-PI_Q29, 0, SMAX, SMIN));
    send_request(make_req(HALF_PI_Q29, 0, 32'hFFFF_FFFF, 1));
    send_request(make_req(SMAX, SMIN, 0, 0));
    // Epoch before J2000 (motion runs backwards; zero epoch is the far extreme), then the largest epoch.
    write_epoch(32'd0);
    send_request(make_req(0, 0, SMAX, SMAX));
    send_request(make_req(SMIN, SMAX, SMIN, SMAX));
    send_request(make_req(HALF_PI_Q29, HALF_PI_Q29, 1000000, -1000000));
    write_epoch(32'hFFFF_FFFF);
    send_request(make_req(0, 0, SMAX, SMIN));
    send_request(make_req(SMIN, SMIN, SMIN, SMIN));
    send_request(make_req(PI_Q29, -HALF_PI_Q29, -1000000, 1000000));
    // Exactly J2000: no motion at all.
    write_epoch(32'd1689010176);
    send_request(make_req(SMAX, SMAX, SMAX, SMAX));
    send_request(make_req(PI_Q29, HALF_PI_Q29, SMIN, SMIN));

    // Random phases: three idling patterns, a fresh epoch before each and another halfway through.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 13; rx_idle_pct = 79; end
        1: begin tx_idle_pct = 79; rx_idle_pct = 13; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      write_epoch(ph == 2 ? sdu_pkg::EPOCH_RESET : $urandom);
      for (int n = 0; n < 330; n++) begin
        if (n == 165) write_epoch(32'd1689010176 + 32'($urandom_range(2000000)));
        send_request(random_req());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_vectors.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_vectors.size() == 0)
      $display("tb_source_direction_unit_vector_top: PASS");
    else
      $display("tb_source_direction_unit_vector_top: FAIL");
    $finish;
  end
endmodule

/* source_direction_unit_vector_top.f */
rtl/core/sdu_pkg.sv
rtl/core/sdu_motion.sv
rtl/core/sdu_sincos.sv
rtl/core/sdu_outbuf.sv
rtl/core/source_direction_unit_vector_top.sv
dv/tb_source_direction_unit_vector_top.sv
